>>> rtl/chacha_pkg.sv
package chacha_pkg;

   localparam int unsigned MAX_REQUEST_BYTES = 8;
   localparam int unsigned WORDS = 16;
   localparam int unsigned LANES = 4;
   localparam int unsigned PADDR_W = 6;
   localparam int unsigned CFG_W = 64;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned POS_W = 7;
   localparam int unsigned STEP_W = 6;

   // ten double rounds, each two half steps for the column and two for the diagonal
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(40 - 1);
   localparam logic [POS_W-1:0] BLOCK_BYTES = POS_W'(64);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_REQUEST_BYTES);

   localparam int unsigned ROT_A = 16;
   localparam int unsigned ROT_B = 12;
   localparam int unsigned ROT_C = 8;
   localparam int unsigned ROT_D = 7;

   localparam logic [31:0] SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   localparam logic CMD_GENERATE = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [2:0] REG_KEY_0 = 3'd0;
   localparam logic [2:0] REG_KEY_1 = 3'd1;
   localparam logic [2:0] REG_KEY_2 = 3'd2;
   localparam logic [2:0] REG_KEY_3 = 3'd3;
   localparam logic [2:0] REG_NONCE = 3'd4;

   typedef struct packed {
      logic [3:0][CFG_W-1:0] key;
      logic [CFG_W-1:0] nonce;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic restart;
      logic load_block;
      logic round_step;
      logic diag;
      logic phase;
      logic finish_block;
      logic serve_byte;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic buf_empty;
      logic req_done;
   } dp_status_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } qr_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // first or second half of a quarter round
   function automatic qr_type qr_half(input qr_type q, input logic phase);
      qr_type r;
      logic [31:0] x;
      r = q;
      r.a = q.a + q.b;
      x = q.d ^ r.a;
      r.d = phase ? rotl32(x, ROT_C) : rotl32(x, ROT_A);
      r.c = q.c + r.d;
      x = q.b ^ r.c;
      r.b = phase ? rotl32(x, ROT_D) : rotl32(x, ROT_B);
      return r;
   endfunction

endpackage

>>> rtl/chacha_csr.sv
module chacha_csr import chacha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [CFG_W-1:0]   pwdata,
   output logic [CFG_W-1:0]   prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type cfg_ff;
   logic [2:0] reg_index;
   logic write_en;

   assign reg_index = paddr[PADDR_W-1:3];
   assign write_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            REG_KEY_0: cfg_ff.key[0] <= pwdata;
            REG_KEY_1: cfg_ff.key[1] <= pwdata;
            REG_KEY_2: cfg_ff.key[2] <= pwdata;
            REG_KEY_3: cfg_ff.key[3] <= pwdata;
            REG_NONCE: cfg_ff.nonce <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_KEY_0: prdata = cfg_ff.key[0];
         REG_KEY_1: prdata = cfg_ff.key[1];
         REG_KEY_2: prdata = cfg_ff.key[2];
         REG_KEY_3: prdata = cfg_ff.key[3];
         REG_NONCE: prdata = cfg_ff.nonce;
         default:   prdata = '0;
      endcase
   end

endmodule

>>> rtl/chacha_dp.sv
module chacha_dp import chacha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  dp_cmd_type         cmd,
   input  logic [COUNT_W-1:0] req_byte_count,
   output dp_status_type      status,
   output logic [63:0]        rsp_data
);

   logic [31:0] w_ff [WORDS];
   logic [31:0] round_w [WORDS];
   logic [31:0] init_w [WORDS];
   logic [31:0] buf_ff [WORDS];
   logic [63:0] counter_ff;
   logic [POS_W-1:0] pos_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] lane_ff;
   logic [63:0] acc_ff;
   logic [63:0] out_ff;
   logic [31:0] rd_word;
   logic [7:0] rd_byte;
   logic [COUNT_W-1:0] sat_count;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_w[i] = SIGMA[i];
         init_w[4 + 2 * i] = cfg.key[i][31:0];
         init_w[5 + 2 * i] = cfg.key[i][63:32];
      end
      init_w[12] = counter_ff[31:0];
      init_w[13] = counter_ff[63:32];
      init_w[14] = cfg.nonce[31:0];
      init_w[15] = cfg.nonce[63:32];
   end

   // four quarter-round lanes; diagonal rounds pick the rotated rows
   qr_type lane_out [LANES];

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      qr_type lane_in;
      assign lane_in.a = w_ff[i];
      assign lane_in.b = cmd.diag ? w_ff[4 + ((i + 1) % 4)] : w_ff[4 + i];
      assign lane_in.c = cmd.diag ? w_ff[8 + ((i + 2) % 4)] : w_ff[8 + i];
      assign lane_in.d = cmd.diag ? w_ff[12 + ((i + 3) % 4)] : w_ff[12 + i];
      assign lane_out[i] = qr_half(lane_in, cmd.phase);
   end

   for (genvar j = 0; j < LANES; j++) begin : g_scatter
      assign round_w[j] = lane_out[j].a;
      assign round_w[4 + j] = cmd.diag ? lane_out[(j + 3) % 4].b : lane_out[j].b;
      assign round_w[8 + j] = cmd.diag ? lane_out[(j + 2) % 4].c : lane_out[j].c;
      assign round_w[12 + j] = cmd.diag ? lane_out[(j + 1) % 4].d : lane_out[j].d;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_block) begin
         w_ff <= init_w;
      end else if (cmd.round_step) begin
         w_ff <= round_w;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_block) begin
         for (int i = 0; i < WORDS; i++) begin
            buf_ff[i] <= w_ff[i] + init_w[i];
         end
      end
   end

   assign rd_word = buf_ff[pos_ff[5:2]];
   assign rd_byte = rd_word[8 * pos_ff[1:0] +: 8];
   assign sat_count = (req_byte_count > MAX_COUNT) ? MAX_COUNT : req_byte_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         pos_ff <= BLOCK_BYTES;
         count_ff <= '0;
         lane_ff <= '0;
      end else begin
         if (cmd.start) begin
            count_ff <= cmd.restart ? '0 : sat_count;
            lane_ff <= '0;
            if (cmd.restart) begin
               counter_ff <= '0;
               pos_ff <= BLOCK_BYTES;
            end
         end
         if (cmd.finish_block) begin
            counter_ff <= counter_ff + 64'd1;
            pos_ff <= '0;
         end
         if (cmd.serve_byte) begin
            pos_ff <= pos_ff + POS_W'(1);
            lane_ff <= lane_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (cmd.serve_byte) begin
         acc_ff[8 * lane_ff[2:0] +: 8] <= rd_byte;
      end
      if (cmd.emit) begin
         out_ff <= acc_ff;
      end
   end

   assign status.buf_empty = pos_ff[POS_W-1];
   assign status.req_done = (lane_ff == count_ff);
   assign rsp_data = out_ff;

endmodule

>>> rtl/chacha_ctrl.sv
module chacha_ctrl import chacha_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_cmd,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_ROUND,
      ST_FINAL
   } state_type;

   state_type state_ff;
   logic [STEP_W-1:0] step_ff;
   logic rsp_valid_ff;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.restart = (req_cmd == CMD_RESTART);
      cmd.diag = step_ff[1];
      cmd.phase = step_ff[0];
      unique case (state_ff)
         ST_IDLE:  cmd.start = req_valid;
         ST_STEP: begin
            priority if (status.req_done) begin
               cmd.emit = out_free;
            end else if (status.buf_empty) begin
               cmd.load_block = 1'b1;
            end else begin
               cmd.serve_byte = 1'b1;
            end
         end
         ST_ROUND: cmd.round_step = 1'b1;
         ST_FINAL: cmd.finish_block = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (cmd.emit) begin
                  state_ff <= ST_IDLE;
               end else if (cmd.load_block) begin
                  step_ff <= '0;
                  state_ff <= ST_ROUND;
               end
            end
            ST_ROUND: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_FINAL;
               end
            end
            ST_FINAL: state_ff <= ST_STEP;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/chacha20_keystream_generator.sv
// restart or a zero byte count gives its result from the step state once the output is free;
// otherwise the bytes are served one by one from the buffered block before the result is emitted
// each new 64-byte block takes a load, 40 half quarter-round steps on four lanes and a final add
// one item at a time; eight 8-byte requests share one block
// synchronous reset: key and nonce registers zero, block counter zero, keystream buffer empty
module chacha20_keystream_generator import chacha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [COUNT_W-1:0] req_byte_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [CFG_W-1:0]   pwdata,
   output logic [CFG_W-1:0]   prdata,
   output logic               pready
);

   cfg_type cfg;
   dp_cmd_type cmd;
   dp_status_type status;

   chacha_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   chacha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   chacha_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .req_byte_count (req_byte_count),
      .status         (status),
      .rsp_data       (rsp_data)
   );

endmodule

>>> rtl/chacha_checker.sv
module chacha_checker import chacha_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_cmd,
   input logic [COUNT_W-1:0] req_byte_count,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [63:0]        rsp_data
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // one item in flight: the input side closes right after an acceptance
   assert property (@(posedge clock) disable iff (reset) req_take |=> req_stall)
      else $error("input accepted while an item was in flight");

   // a new result shows up only as the block finishes an item and reopens
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> $fell(req_stall))
      else $error("result appeared without finishing an item");

   // restart or empty request, taken while no result is waiting, gives a zero result
   assert property (@(posedge clock) disable iff (reset)
      req_take && !rsp_valid && (req_cmd == CMD_RESTART || req_byte_count == '0)
      |=> ##1 (rsp_valid && rsp_data == '0))
      else $error("restart or empty request did not give a zero result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind chacha20_keystream_generator chacha_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_cmd        (req_cmd),
   .req_byte_count (req_byte_count),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data       (rsp_data)
);
